// ===== src/bft_pkg.sv =====
// shared types and constants for the bloom filter test-and-insert block
package bft_pkg;

	localparam int PROBES         = 4;
	localparam int PROBE_W        = 10 + 10;
	localparam int INDEX_BITS_DEF = 20;
	localparam int WORD_BITS      = 32;
	localparam int COUNT_W        = 32;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	typedef logic [PROBE_W-1:0] probe_t;

	typedef struct packed {
		probe_t [PROBES-1:0] idx;
		logic   [PROBES-1:0] dup;
	} probe_item_t;

	typedef struct packed {
		logic               valid;
		probe_item_t        item;
	} front_out_t;

	typedef struct packed {
		logic               pop;
		logic               clearing;
	} back_status_t;

	typedef struct packed {
		logic               hit;
		logic [COUNT_W-1:0] present;
		logic [COUNT_W-1:0] fresh;
	} result_t;

endpackage

// ===== src/bft_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
module bft_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/bft_front.sv =====
// front end: takes items, flags repeated probe indices, holds them in a short queue
module bft_front import bft_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  probe_t       probe_index_0,
	input  probe_t       probe_index_1,
	input  probe_t       probe_index_2,
	input  probe_t       probe_index_3,
	input  back_status_t back_st,
	output front_out_t   front_out
);

	probe_item_t             q_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]       wr_ptr_q;
	logic [QPTR_W-1:0]       rd_ptr_q;
	logic [QCNT_W-1:0]       cnt_q;
	logic                    accept;
	logic                    pop;
	probe_item_t             cls;
	logic [INDEX_BITS-1:0]   tr [PROBES];

	assign in_stall = back_st.clearing || (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign accept   = in_valid && !in_stall;
	assign pop      = back_st.pop;

	// a probe that hits the same store bit as an earlier probe must not see its own write
	always_comb begin
		cls.idx[0] = probe_index_0;
		cls.idx[1] = probe_index_1;
		cls.idx[2] = probe_index_2;
		cls.idx[3] = probe_index_3;
		for (int k = 0; k < PROBES; k++) begin
			tr[k] = INDEX_BITS'(cls.idx[k]);
		end
		for (int k = 0; k < PROBES; k++) begin
			cls.dup[k] = 1'b0;
			for (int j = 0; j < k; j++) begin
				if (tr[j] == tr[k]) begin
					cls.dup[k] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (accept && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !accept) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign front_out.valid = (cnt_q != '0);
	assign front_out.item  = q_q[rd_ptr_q];

endmodule

// ===== src/bft_back.sv =====
// back end: store clearing pass, probe read-modify-write, counters and result queue
module bft_back import bft_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  front_out_t         front_out,
	output back_status_t       back_st,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               already_present,
	output logic [COUNT_W-1:0] present_total,
	output logic [COUNT_W-1:0] new_total
);

	localparam int OFS_BITS = $clog2(WORD_BITS);
	localparam int ROW_BITS = INDEX_BITS - OFS_BITS;
	localparam int DEPTH    = 1 << ROW_BITS;

	// clearing pass
	logic                  clr_q;
	logic [ROW_BITS-1:0]   clr_row_q;

	// issue side
	logic [1:0]            iss_k_q;
	logic [INDEX_BITS-1:0] iss_idx;
	logic                  issue;
	logic                  start;
	logic                  start_ok;
	logic                  inflight_q;

	// data side
	logic                  v_s1;
	logic [OFS_BITS-1:0]   ofs_s1;
	logic [ROW_BITS-1:0]   row_s1;
	logic                  dup_s1;
	logic                  first_s1;
	logic                  last_s1;
	logic                  all_q;
	logic                  all_now;
	logic                  push;
	logic [WORD_BITS-1:0]  rdata;
	logic [WORD_BITS-1:0]  rd_word;
	logic                  fwd_hit_q;
	logic [WORD_BITS-1:0]  fwd_data_q;

	// ram ports
	logic                  we;
	logic [ROW_BITS-1:0]   waddr;
	logic [WORD_BITS-1:0]  wdata;
	logic [ROW_BITS-1:0]   raddr;

	// counters and result queue
	logic [COUNT_W-1:0]    present_q;
	logic [COUNT_W-1:0]    new_q;
	result_t               res;
	result_t               oq_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]     owr_q;
	logic [QPTR_W-1:0]     ord_q;
	logic [QCNT_W-1:0]     ocnt_q;
	logic                  opop;

	assign iss_idx  = INDEX_BITS'(front_out.item.idx[iss_k_q]);
	// only start an item when the result queue is sure to have room for it
	assign start_ok = (ocnt_q + QCNT_W'(inflight_q)) < QCNT_W'(QUEUE_DEPTH);
	assign issue    = !clr_q && front_out.valid && ((iss_k_q != 2'd0) || start_ok);
	assign start    = issue && (iss_k_q == 2'd0);
	assign raddr    = iss_idx[INDEX_BITS-1:OFS_BITS];

	assign back_st.pop      = issue && (iss_k_q == 2'(PROBES - 1));
	assign back_st.clearing = clr_q;

	// the word written at the same edge as the read returns stale data, so take it from the bypass
	assign rd_word = fwd_hit_q ? fwd_data_q : rdata;
	assign all_now = (rd_word[ofs_s1] | dup_s1) & (first_s1 | all_q);
	assign push    = v_s1 && last_s1;

	// setting a bit that is already set changes nothing, so every probe is written back
	assign we    = clr_q || v_s1;
	assign waddr = clr_q ? clr_row_q : row_s1;
	assign wdata = clr_q ? '0 : (rd_word | (WORD_BITS'(1) << ofs_s1));

	bft_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		res.hit     = all_now;
		res.present = all_now ? present_q + 1'b1 : present_q;
		res.fresh   = all_now ? new_q : new_q + 1'b1;
	end

	assign opop = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		ofs_s1     <= iss_idx[OFS_BITS-1:0];
		row_s1     <= raddr;
		dup_s1     <= front_out.item.dup[iss_k_q];
		first_s1   <= (iss_k_q == 2'd0);
		last_s1    <= (iss_k_q == 2'(PROBES - 1));
		fwd_data_q <= wdata;
		if (v_s1) begin
			all_q <= all_now;
		end
		if (push) begin
			oq_q[owr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_row_q  <= '0;
			iss_k_q    <= '0;
			inflight_q <= 1'b0;
			v_s1       <= 1'b0;
			fwd_hit_q  <= 1'b0;
			present_q  <= '0;
			new_q      <= '0;
			owr_q      <= '0;
			ord_q      <= '0;
			ocnt_q     <= '0;
		end else begin
			if (clr_q) begin
				clr_row_q <= clr_row_q + 1'b1;
				if (clr_row_q == '1) begin
					clr_q <= 1'b0;
				end
			end
			if (issue) begin
				iss_k_q <= iss_k_q + 1'b1;
			end
			if (start && !push) begin
				inflight_q <= 1'b1;
			end else if (push && !start) begin
				inflight_q <= 1'b0;
			end
			v_s1      <= issue;
			fwd_hit_q <= we && (waddr == raddr);
			if (push) begin
				present_q <= res.present;
				new_q     <= res.fresh;
				owr_q     <= owr_q + 1'b1;
			end
			if (opop) begin
				ord_q <= ord_q + 1'b1;
			end
			if (push && !opop) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (opop && !push) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

	assign out_valid       = (ocnt_q != '0);
	assign already_present = oq_q[ord_q].hit;
	assign present_total   = oq_q[ord_q].present;
	assign new_total       = oq_q[ord_q].fresh;

endmodule

// ===== src/bloom_filter_test_insert.sv =====
// top level of the bloom filter test-and-insert engine
//
//  channel | direction | handshake           | payload
//  in      | in        | in_valid / in_stall | probe_index_0 .. probe_index_3
//  out     | out       | out_valid/out_stall | already_present, present_total, new_total
//
// in the back end each item takes one store read and one read-modify-write per probe on
// the single-read, single-write word ram; a new item may start before the last one's result is queued.
// after reset the store is cleared one 32-bit row a cycle, all 2^(INDEX_BITS-5) rows
// (32768 by default), with in_stall high throughout.
// a two-entry queue on each side lets input and output stall independently.
module bloom_filter_test_insert import bft_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  probe_t             probe_index_0,
	input  probe_t             probe_index_1,
	input  probe_t             probe_index_2,
	input  probe_t             probe_index_3,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               already_present,
	output logic [COUNT_W-1:0] present_total,
	output logic [COUNT_W-1:0] new_total
);

	front_out_t   front_out;
	back_status_t back_st;

	bft_front #(
		.INDEX_BITS (INDEX_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.probe_index_0 (probe_index_0),
		.probe_index_1 (probe_index_1),
		.probe_index_2 (probe_index_2),
		.probe_index_3 (probe_index_3),
		.back_st       (back_st),
		.front_out     (front_out)
	);

	bft_back #(
		.INDEX_BITS (INDEX_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.front_out       (front_out),
		.back_st         (back_st),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.already_present (already_present),
		.present_total   (present_total),
		.new_total       (new_total)
	);

endmodule

// ===== src/bft_checker.sv =====
// port-level checks for the bloom filter engine, bound to the top level
module bft_checker import bft_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               already_present,
	input logic [COUNT_W-1:0] present_total,
	input logic [COUNT_W-1:0] new_total
);

	logic               seen_q;
	logic [COUNT_W-1:0] last_p_q;
	logic [COUNT_W-1:0] last_n_q;
	logic [COUNT_W-1:0] pending_q;
	logic               in_acc;
	logic               out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			last_p_q  <= '0;
			last_n_q  <= '0;
			pending_q <= '0;
		end else begin
			if (out_acc) begin
				seen_q   <= 1'b1;
				last_p_q <= present_total;
				last_n_q <= new_total;
			end
			if (in_acc && !out_acc) begin
				pending_q <= pending_q + 1'b1;
			end else if (out_acc && !in_acc) begin
				pending_q <= pending_q - 1'b1;
			end
		end
	end

	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(already_present)
			&& $stable(present_total) && $stable(new_total))
		else $error("stalled result changed");

	// exactly one of the two counters steps per item, as the flag says
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_q |->
			(already_present && present_total == last_p_q + 1'b1 && new_total == last_n_q) ||
			(!already_present && new_total == last_n_q + 1'b1 && present_total == last_p_q))
		else $error("counter step mismatch");

	// the first item after reset meets an empty store
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !seen_q |-> !already_present && new_total == 1 && present_total == 0)
		else $error("first result not new");

	// no result without an accepted item
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 0)
		else $error("result without item");

endmodule

bind bloom_filter_test_insert bft_checker u_checker (.*);

// ===== dv/tb_bloom_filter_test_insert.sv =====
// self-checking testbench for the bloom filter test-and-insert engine
module tb_bloom_filter_test_insert;
	import bft_pkg::*;

	localparam int          INDEX_BITS  = INDEX_BITS_DEF;
	localparam int unsigned INDEX_MASK  = (1 << INDEX_BITS) - 1;
	localparam int          STALL_LIMIT = 100000;
	localparam int          PHASE_ITEMS = 165;

	typedef probe_t [PROBES-1:0] probe_set_t;

	class bloom_ledger;
		bit                 marked[int unsigned];
		result_t            expected_results[$];
		logic [COUNT_W-1:0] hit_count    = '0;
		logic [COUNT_W-1:0] insert_count = '0;
		int                 mismatches   = 0;
		int                 hits_seen    = 0;
		int                 inserts_seen = 0;

		// work out the result of one accepted item and update the filter copy
		function void note_probe_set(probe_set_t s);
			result_t     r;
			bit          all_marked;
			int unsigned key;
			all_marked = 1'b1;
			for (int k = 0; k < PROBES; k++) begin
				key = 32'(s[k]);
				key &= INDEX_MASK;
				if (!marked.exists(key))
					all_marked = 1'b0;
			end
			if (all_marked) begin
				hit_count++;
			end else begin
				insert_count++;
				for (int k = 0; k < PROBES; k++) begin
					key = 32'(s[k]);
					key &= INDEX_MASK;
					marked[key] = 1'b1;
				end
			end
			r.hit     = all_marked;
			r.present = hit_count;
			r.fresh   = insert_count;
			expected_results.push_back(r);
		endfunction

		function void check_result(logic hit, logic [COUNT_W-1:0] present,
				logic [COUNT_W-1:0] fresh);
			result_t want;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: hit=%b present=%0d new=%0d",
						hit, present, fresh);
				return;
			end
			want = expected_results.pop_front();
			if (want.hit)
				hits_seen++;
			else
				inserts_seen++;
			if (hit !== want.hit || present !== want.present || fresh !== want.fresh) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: want hit=%b p=%0d n=%0d, got hit=%b p=%0d n=%0d",
						want.hit, want.present, want.fresh, hit, present, fresh);
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic               clk             = 1'b0;
	logic               arst_n          = 1'b0;
	logic               in_valid        = 1'b0;
	logic               in_stall;
	probe_t             probe_index_0   = '0;
	probe_t             probe_index_1   = '0;
	probe_t             probe_index_2   = '0;
	probe_t             probe_index_3   = '0;
	logic               out_valid;
	logic               out_stall       = 1'b0;
	logic               already_present;
	logic [COUNT_W-1:0] present_total;
	logic [COUNT_W-1:0] new_total;

	bloom_ledger ledger = new();
	int          in_idle_pct  = 30;
	int          out_idle_pct = 45;
	int          quiet_cycles = 0;
	probe_set_t  past_sets[$];
	probe_t      past_idx[$];

	// repeats, reorders, sets built from bits of other items, partial overlaps
	probe_set_t directed_sets [14] = '{
		{20'h00000, 20'h00000, 20'h00000, 20'h00000},
		{20'h00000, 20'h00000, 20'h00000, 20'h00000},
		{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF},
		{20'hFFFFF, 20'h00000, 20'hFFFFF, 20'h00000},
		{20'h00008, 20'h00004, 20'h00002, 20'h00001},
		{20'h00008, 20'h00004, 20'h00002, 20'h00001},
		{20'h00010, 20'h00004, 20'h00002, 20'h00001},
		{20'h00001, 20'h00002, 20'h00008, 20'h00010},
		{20'hF0F0F, 20'h0F0F0, 20'h55555, 20'hAAAAA},
		{20'hAAAAA, 20'h55555, 20'h0F0F0, 20'hF0F0F},
		{20'h54321, 20'h12345, 20'h54321, 20'h12345},
		{20'h12345, 20'h12345, 20'h54321, 20'h54321},
		{20'hFFFFF, 20'h00000, 20'h00001, 20'hAAAAA},
		{20'hFFFFE, 20'h00000, 20'h00000, 20'h00000}
	};

	bloom_filter_test_insert dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.probe_index_0   (probe_index_0),
		.probe_index_1   (probe_index_1),
		.probe_index_2   (probe_index_2),
		.probe_index_3   (probe_index_3),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.already_present (already_present),
		.present_total   (present_total),
		.new_total       (new_total)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			ledger.check_result(already_present, present_total, new_total);
		out_stall <= ($urandom_range(99) < out_idle_pct);
	end

	// covers the store clearing pass after reset as well as a hung handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles without a handshake", quiet_cycles);
			$display("tb_bloom_filter_test_insert NOT OK");
			$finish;
		end
	end

	// mostly sets that reuse known bits, so that hits are frequent
	function automatic probe_set_t pick_probe_set();
		probe_set_t  s;
		probe_set_t  old;
		int unsigned mode;
		int unsigned rot;
		mode = $urandom_range(99);
		for (int k = 0; k < PROBES; k++)
			s[k] = probe_t'($urandom);
		if (mode < 35) begin
			old = past_sets[$urandom_range(past_sets.size() - 1)];
			rot = $urandom_range(PROBES - 1);
			for (int k = 0; k < PROBES; k++)
				s[k] = old[(k + rot) % PROBES];
		end else if (mode < 55) begin
			for (int k = 0; k < PROBES; k++)
				s[k] = past_idx[$urandom_range(past_idx.size() - 1)];
		end else if (mode < 75) begin
			for (int k = 0; k < 2; k++)
				s[$urandom_range(PROBES - 1)] = past_idx[$urandom_range(past_idx.size() - 1)];
		end else if (mode < 85) begin
			for (int k = 0; k < PROBES; k++)
				s[k] = probe_t'($urandom_range(63));
		end
		return s;
	endfunction

	task automatic drive_item(probe_set_t s);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		probe_index_0 <= s[0];
		probe_index_1 <= s[1];
		probe_index_2 <= s[2];
		probe_index_3 <= s[3];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		ledger.note_probe_set(s);
		past_sets.push_back(s);
		for (int k = 0; k < PROBES; k++)
			past_idx.push_back(s[k]);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (ledger.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 3; ph++) begin
			in_idle_pct  = (ph == 0) ? 30 : (ph == 1) ? 45 : 0;
			out_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 30 : 0;
			if (ph == 0)
				foreach (directed_sets[i])
					drive_item(directed_sets[i]);
			repeat (PHASE_ITEMS)
				drive_item(pick_probe_set());
			drain();
		end
		repeat (20) @(posedge clk);
		$display("checked %0d items: %0d already present, %0d inserted as new",
			past_sets.size(), ledger.hits_seen, ledger.inserts_seen);
		$display("stall mixes: sender-heavy, receiver-heavy and none; %0d mismatches",
			ledger.mismatches);
		if (ledger.mismatches == 0 && ledger.pending() == 0)
			$display("tb_bloom_filter_test_insert OK");
		else
			$display("tb_bloom_filter_test_insert NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/bft_pkg.sv
src/bft_ram.sv
src/bft_front.sv
src/bft_back.sv
src/bloom_filter_test_insert.sv
src/bft_checker.sv
dv/tb_bloom_filter_test_insert.sv
